FILE: rtl/core/tist_pkg.sv
// Transaction id slot table: shared types and constants.
// No dependencies; used by every file under rtl/core except tist_ram.
package tist_pkg;

    localparam int ID_W      = 96;
    localparam int ID_LOW_W  = 64;
    localparam int CFG_W     = 5;
    localparam int IN_DATA_W = 96;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef logic [ID_W-1:0] t_id;

    typedef struct packed {
        logic    vld;
        t_status status;
    } t_res;

endpackage

FILE: rtl/core/transaction_id_slot_table_unit.sv
// Transaction id slot table, top level: config register, id RAM, sequencer, output register.
// Depends on tist_pkg, tist_ram and tist_ctrl.
//
//  channel   | dir | fields
//  s_axis    | in  | tuser: command; tdata: id_low, id_high
//  m_axis    | out | tdata: status
//  cfg write | in  | active_slots
//
// Insert scans the valid bits from slot 0 below live and writes the id into the lowest free slot.
// Lookup/remove scan one slot a cycle through the RAM read port, over the live slots.
// Clear drops all valid bits at once. live = min(active_slots, SLOT_COUNT).
// Reset clears all valid bits at once; no clearing pass.
// A result waits in the output register while the next item is taken.
module transaction_id_slot_table_unit #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tist_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // id_low [63:0], id_high [95:64]
    input  logic [tist_pkg::IN_USER_W-1:0]   s_axis_tuser,  // command [1:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tist_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // status [1:0], zeros above
    input  logic                             i_cfg_wr_en,
    input  logic [tist_pkg::CFG_W-1:0]       i_cfg_wr_data
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = ($clog2(SLOT_COUNT+1) > tist_pkg::CFG_W) ?
                           $clog2(SLOT_COUNT+1) : tist_pkg::CFG_W;

    logic [tist_pkg::CFG_W-1:0] r_active;
    logic [CNT_W-1:0]           active_ext;
    logic [CNT_W-1:0]           live;

    logic              r_out_vld;
    tist_pkg::t_status r_out_status;

    logic              idle;
    logic              start;
    logic              res_take;
    tist_pkg::t_res    res;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
    tist_pkg::t_id     wr_data;
    tist_pkg::t_id     rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= tist_pkg::ACTIVE_RESET;
        end else if (i_cfg_wr_en) begin
            r_active <= i_cfg_wr_data;
        end
    end

    assign active_ext = CNT_W'(r_active);
    assign live = (active_ext > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT) : active_ext;

    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;
    assign res_take      = res.vld && (!r_out_vld || m_axis_tready);

    tist_ram #(
        .WIDTH (tist_pkg::ID_W),
        .DEPTH (SLOT_COUNT)
    ) u_id_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tist_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (tist_pkg::t_cmd'(s_axis_tuser)),
        .i_id       (s_axis_tdata),
        .i_live     (live),
        .i_res_take (res_take),
        .o_idle     (idle),
        .o_res      (res),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_status <= res.status;
        end
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(tist_pkg::OUT_DATA_W-2){1'b0}}, r_out_status};

endmodule

FILE: rtl/core/tist_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tist_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/tist_ctrl.sv
// Slot table sequencer: valid bits, slot scan counter and the shared id comparator.
// Depends on tist_pkg; drives the id RAM in the top level.
module tist_ctrl #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  tist_pkg::t_cmd            i_cmd,
    input  tist_pkg::t_id             i_id,
    input  logic [((($clog2(SLOT_COUNT+1)) > tist_pkg::CFG_W) ?
                   $clog2(SLOT_COUNT+1) : tist_pkg::CFG_W)-1:0] i_live,
    input  logic                      i_res_take,
    output logic                      o_idle,
    output tist_pkg::t_res            o_res,
    output logic                      o_wr_en,
    output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] o_wr_addr,
    output tist_pkg::t_id             o_wr_data,
    output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] o_rd_addr,
    input  tist_pkg::t_id             i_rd_data
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = ($clog2(SLOT_COUNT+1) > tist_pkg::CFG_W) ?
                           $clog2(SLOT_COUNT+1) : tist_pkg::CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_SRCH,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [IDX_W-1:0]      r_pidx, n_pidx;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    tist_pkg::t_status     r_status, n_status;
    tist_pkg::t_cmd        r_cmd, n_cmd;
    tist_pkg::t_id         r_id, n_id;

    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic             hit;
    logic             wr_en;

    assign in_range = (r_idx < i_live);
    assign idx      = r_idx[IDX_W-1:0];
    // comparison of the slot read in the previous cycle
    assign hit      = r_pend && r_valid[r_pidx] && (i_rd_data == r_id);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pend   = 1'b0;
        n_pidx   = r_pidx;
        n_valid  = r_valid;
        n_status = r_status;
        n_cmd    = r_cmd;
        n_id     = r_id;
        wr_en    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_cmd;
                    n_id  = i_id;
                    n_idx = '0;
                    case (i_cmd)
                        tist_pkg::CMD_CLEAR: begin
                            n_valid  = '0;
                            n_status = tist_pkg::ST_OK;
                            n_state  = S_DONE;
                        end
                        tist_pkg::CMD_INSERT: n_state = S_INS;
                        default:              n_state = S_SRCH;
                    endcase
                end
            end
            S_INS: begin
                if (!in_range) begin
                    n_status = tist_pkg::ST_FULL;
                    n_state  = S_DONE;
                end else if (!r_valid[idx]) begin
                    wr_en        = 1'b1;
                    n_valid[idx] = 1'b1;
                    n_status     = tist_pkg::ST_OK;
                    n_state      = S_DONE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_SRCH: begin
                if (hit) begin
                    if (r_cmd == tist_pkg::CMD_REMOVE) begin
                        n_valid[r_pidx] = 1'b0;
                    end
                    n_status = tist_pkg::ST_OK;
                    n_state  = S_DONE;
                end else if (!in_range) begin
                    n_status = tist_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_pend = 1'b1;
                    n_pidx = idx;
                    n_idx  = r_idx + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_status <= n_status;
        r_cmd    <= n_cmd;
        r_id     <= n_id;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    assign o_idle         = (r_state == S_IDLE);
    assign o_res.vld      = (r_state == S_DONE);
    assign o_res.status   = r_status;
    assign o_wr_en        = wr_en;
    assign o_wr_addr      = idx;
    assign o_wr_data      = r_id;
    assign o_rd_addr      = idx;

endmodule

FILE: rtl/core/tist_checker.sv
// Port-level checks for the transaction id slot table.
// Depends on tist_pkg; bound to transaction_id_slot_table_unit below.
module tist_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tist_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("status code out of range");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[tist_pkg::OUT_DATA_W-1:2] == '0))
        else $error("tdata padding not zero");

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item taken while previous one still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind transaction_id_slot_table_unit tist_checker u_tist_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/tb_transaction_id_slot_table_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for transaction_id_slot_table_unit: stream traffic
// with random idling against a scoreboard class that tracks slot contents.
// Depends on tist_pkg and the RTL under rtl/core.
module tb_transaction_id_slot_table_unit;

    localparam int SLOT_COUNT = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = SLOT_COUNT + 6;
    localparam int PHASES = 9;

    class slot_table_scoreboard;
        bit [tist_pkg::CFG_W-1:0] active_slots;
        bit                       slot_valid [SLOT_COUNT];
        tist_pkg::t_id            slot_id [SLOT_COUNT];
        tist_pkg::t_status        status_due [$];
        int unsigned              mismatches;

        function new();
            active_slots = tist_pkg::ACTIVE_RESET;
            foreach (slot_valid[k]) begin
                slot_valid[k] = 1'b0;
                slot_id[k] = '0;
            end
            mismatches = 0;
        endfunction

        function void set_active(bit [tist_pkg::CFG_W-1:0] value);
            active_slots = value;
        endfunction

        function int live_slots();
            return (active_slots > SLOT_COUNT) ? SLOT_COUNT : int'(active_slots);
        endfunction

        function int lowest_match(tist_pkg::t_id id);
            for (int k = 0; k < live_slots(); k++) begin
                if (slot_valid[k] && slot_id[k] == id) return k;
            end
            return -1;
        endfunction

        function void note_item(tist_pkg::t_cmd cmd, tist_pkg::t_id id);
            tist_pkg::t_status st;
            int m;
            st = tist_pkg::ST_OK;
            case (cmd)
                tist_pkg::CMD_INSERT: begin
                    st = tist_pkg::ST_FULL;
                    for (int k = 0; k < live_slots(); k++) begin
                        if (!slot_valid[k]) begin
                            slot_valid[k] = 1'b1;
                            slot_id[k] = id;
                            st = tist_pkg::ST_OK;
                            break;
                        end
                    end
                end
                tist_pkg::CMD_LOOKUP: begin
                    st = (lowest_match(id) >= 0) ? tist_pkg::ST_OK : tist_pkg::ST_NOT_FOUND;
                end
                tist_pkg::CMD_REMOVE: begin
                    m = lowest_match(id);
                    if (m >= 0) begin
                        slot_valid[m] = 1'b0;
                        slot_id[m] = '0;
                    end else begin
                        st = tist_pkg::ST_NOT_FOUND;
                    end
                end
                default: begin
                    foreach (slot_valid[k]) slot_valid[k] = 1'b0;
                end
            endcase
            status_due.push_back(st);
        endfunction

        function void check_status(logic [1:0] got);
            tist_pkg::t_status want;
            if (status_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: status %0d with no item outstanding", $realtime, got);
                return;
            end
            want = status_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: status expected %0d got %0d", $realtime, want, got);
            end
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [tist_pkg::IN_DATA_W-1:0]    s_axis_tdata;   // id_low [63:0], id_high [95:64]
    logic [tist_pkg::IN_USER_W-1:0]    s_axis_tuser;   // command [1:0]
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [tist_pkg::OUT_DATA_W-1:0]   m_axis_tdata;   // status [1:0], zeros above
    logic                              i_cfg_wr_en;
    logic [tist_pkg::CFG_W-1:0]        i_cfg_wr_data;

    slot_table_scoreboard sb = new();
    bit steady_run = 1'b0;
    int unsigned quiet_cycles = 0;
    tist_pkg::t_id id_pool [8];
    bit [tist_pkg::CFG_W-1:0] active_plan [PHASES] =
        '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd17, 5'd16, 5'd5, 5'd31};

    transaction_id_slot_table_unit #(.SLOT_COUNT(SLOT_COUNT)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= steady_run ? 1'b1 : ($urandom_range(99) >= 30);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata[1:0]);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_transaction_id_slot_table_unit: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called and returns at a falling edge; valid stays high between back-to-back items.
    task automatic send_item(tist_pkg::t_cmd cmd, tist_pkg::t_id id);
        while (!steady_run && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= id;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_item(cmd, id);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_active(bit [tist_pkg::CFG_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_active(value);
    endtask

    function automatic tist_pkg::t_id random_id();
        return {$urandom, $urandom, $urandom};
    endfunction

    function automatic tist_pkg::t_cmd pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 40) return tist_pkg::CMD_INSERT;
        if (r < 65) return tist_pkg::CMD_LOOKUP;
        if (r < 95) return tist_pkg::CMD_REMOVE;
        return tist_pkg::CMD_CLEAR;
    endfunction

    task automatic run_random(int count);
        tist_pkg::t_id id;
        foreach (id_pool[k]) begin
            if (k > 0 && $urandom_range(99) < 20)
                id_pool[k] = id_pool[k-1] ^
                             (tist_pkg::t_id'(1) << $urandom_range(tist_pkg::ID_W-1));
            else
                id_pool[k] = random_id();
        end
        id_pool[7] = ($urandom_range(1)) ? '1 : '0;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 && $urandom_range(1)) drain();
            id = ($urandom_range(99) < 90) ? id_pool[$urandom_range(7)] : random_id();
            send_item(pick_cmd(), id);
        end
    endtask

    initial begin
        tist_pkg::t_id id_zero, id_ones, id_hi_only, id_lo_only;
        id_zero    = '0;
        id_ones    = '1;
        id_hi_only = {32'hFFFF_FFFF, 64'h0};
        id_lo_only = {32'h0, 64'hFFFF_FFFF_FFFF_FFFF};

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tist_pkg::CMD_INSERT;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: duplicates, near misses, clear
        send_item(tist_pkg::CMD_INSERT, id_zero);
        send_item(tist_pkg::CMD_INSERT, id_ones);
        send_item(tist_pkg::CMD_INSERT, id_ones);
        send_item(tist_pkg::CMD_LOOKUP, id_ones);
        send_item(tist_pkg::CMD_LOOKUP, id_hi_only);
        send_item(tist_pkg::CMD_REMOVE, id_ones);
        send_item(tist_pkg::CMD_LOOKUP, id_ones);
        send_item(tist_pkg::CMD_REMOVE, id_ones);
        send_item(tist_pkg::CMD_REMOVE, id_ones);
        send_item(tist_pkg::CMD_LOOKUP, id_lo_only);
        send_item(tist_pkg::CMD_LOOKUP, id_zero);
        send_item(tist_pkg::CMD_CLEAR, id_zero);
        send_item(tist_pkg::CMD_LOOKUP, id_zero);

        // small table: full, reuse of a freed slot
        write_active(5'd2);
        send_item(tist_pkg::CMD_INSERT, id_lo_only);
        send_item(tist_pkg::CMD_INSERT, id_hi_only);
        send_item(tist_pkg::CMD_INSERT, id_zero);
        send_item(tist_pkg::CMD_REMOVE, id_lo_only);
        send_item(tist_pkg::CMD_INSERT, id_zero);

        // slots beyond the active range are ignored but kept
        write_active(5'd1);
        send_item(tist_pkg::CMD_LOOKUP, id_hi_only);
        send_item(tist_pkg::CMD_INSERT, id_ones);
        write_active(5'd0);
        send_item(tist_pkg::CMD_INSERT, id_ones);
        send_item(tist_pkg::CMD_LOOKUP, id_zero);
        send_item(tist_pkg::CMD_REMOVE, id_zero);
        write_active(5'd31);
        send_item(tist_pkg::CMD_LOOKUP, id_hi_only);
        send_item(tist_pkg::CMD_CLEAR, id_ones);

        for (int p = 0; p < PHASES; p++) begin
            write_active(active_plan[p]);
            steady_run = (p == 6);
            run_random(120);
        end
        steady_run = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_transaction_id_slot_table_unit: clean");
        end else begin
            $display("tb_transaction_id_slot_table_unit: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/tist_pkg.sv
rtl/core/tist_ram.sv
rtl/core/tist_ctrl.sv
rtl/core/transaction_id_slot_table_unit.sv
rtl/core/tist_checker.sv
dv/tb_transaction_id_slot_table_unit.sv
